>>> rtl/fba_pkg.sv
// fba_pkg: shared types, codes and defaults for the free block fifo allocator
// no dependencies; used by every module under rtl
`default_nettype none

package fba_pkg;

   // fixed field widths
   localparam int BLOCK_W = 10;
   localparam int COUNT_W = 11;
   localparam int REQ_W   = 7;

   // defaults for the top level parameters
   localparam int DEF_MAX_BLOCKS = 1024;
   localparam int DEF_MAX_BURST  = 64;

   // depth of the result queue
   localparam int RSP_DEPTH = 4;

   // reset value of the block total register
   localparam logic [COUNT_W-1:0] CSR_TOTAL_RESET = 11'd1024;

   // operation codes
   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [REQ_W-1:0]   block_count;
      logic [BLOCK_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] granted_block;
      logic               index_valid;
      logic [1:0]         status;
      logic [COUNT_W-1:0] free_count;
      logic               last;
   } rsp_type;

   // classified command between front and back
   typedef enum logic [2:0] {
      CMD_INIT  = 3'd0,
      CMD_ALLOC = 3'd1,
      CMD_FREE  = 3'd2,
      CMD_ZERO  = 3'd3,
      CMD_RANGE = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [REQ_W-1:0]   count;
      logic [BLOCK_W-1:0] index;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_ALLOC = 2'b10
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/fba_front.sv
// fba_front: accepts request transactions, classifies them, two-entry command queue
// depends on fba_pkg
`default_nettype none

module fba_front #(
   parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_BURST  = fba_pkg::DEF_MAX_BURST
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire fba_pkg::req_type     req_data,
   input  wire logic [$clog2(MAX_BLOCKS+1)-1:0] total,
   output logic                      cmd_valid,
   output fba_pkg::cmd_type          cmd_data,
   input  wire logic                 cmd_pop
);

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = (CW > fba_pkg::BLOCK_W) ? CW : fba_pkg::BLOCK_W;

   fba_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   fba_pkg::cmd_type cmd_new;
   logic             accept;
   logic             enq;
   logic             deq;

   // classification
   always_comb begin
      cmd_new       = '0;
      cmd_new.index = req_data.block_index;
      enq           = 1'b0;
      unique case (req_data.operation)
         fba_pkg::OP_INIT: begin
            cmd_new.kind = fba_pkg::CMD_INIT;
            enq          = 1'b1;
         end
         fba_pkg::OP_ALLOC: begin
            if (req_data.block_count > fba_pkg::REQ_W'(MAX_BURST)) begin
               cmd_new.count = fba_pkg::REQ_W'(MAX_BURST);
            end else begin
               cmd_new.count = req_data.block_count;
            end
            cmd_new.kind = (req_data.block_count == '0) ? fba_pkg::CMD_ZERO
                                                        : fba_pkg::CMD_ALLOC;
            enq          = 1'b1;
         end
         fba_pkg::OP_FREE: begin
            cmd_new.kind = (XW'(req_data.block_index) >= XW'(total)) ? fba_pkg::CMD_RANGE
                                                                     : fba_pkg::CMD_FREE;
            enq          = 1'b1;
         end
         default: begin
            // unused code: taken and dropped
            cmd_new.kind = fba_pkg::CMD_ZERO;
            enq          = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign deq       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && enq) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (deq) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((accept && enq) && !deq) begin
         count_in = count_ff + 2'd1;
      end else if (!(accept && enq) && deq) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && enq) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fba_rsp_queue.sv
// fba_rsp_queue: small result queue facing the rsp_ ports
// depends on fba_pkg
`default_nettype none

module fba_rsp_queue #(
   parameter int DEPTH = fba_pkg::RSP_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire fba_pkg::rsp_type           push_data,
   input  wire logic                       pop,
   output logic                            empty,
   output fba_pkg::rsp_type                head_data,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   fba_pkg::rsp_type entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             deq;

   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign deq       = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !deq) begin
         count_in = count_ff + NW'(1);
      end else if (!push && deq) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fba_back.sv
// fba_back: executes commands against the free ring memory and pointers
// depends on fba_pkg; feeds fba_rsp_queue
`default_nettype none

module fba_back #(
   parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [$clog2(MAX_BLOCKS+1)-1:0] total,
   input  wire logic                            cmd_valid,
   input  wire fba_pkg::cmd_type                cmd_data,
   output logic                                 cmd_pop,
   input  wire logic [$clog2(fba_pkg::RSP_DEPTH+1)-1:0] rsp_count,
   output logic                                 rsp_push,
   output fba_pkg::rsp_type                     rsp_data
);

   localparam int PW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = (CW > fba_pkg::REQ_W) ? CW : fba_pkg::REQ_W;
   localparam int QW = $clog2(fba_pkg::RSP_DEPTH + 1) + 1;

   // ring memory
   logic [fba_pkg::BLOCK_W-1:0] ring_mem [MAX_BLOCKS];
   logic [fba_pkg::BLOCK_W-1:0] mem_q_ff;
   logic                        mem_we;
   logic                        mem_re;

   fba_pkg::back_state_type     state_ff, state_in;
   logic [PW-1:0]               head_ff, head_in;
   logic [PW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               free_ff, free_in;
   logic [PW-1:0]               init_tail_ff, init_tail_in;
   logic [CW-1:0]               push_cnt_ff, push_cnt_in;
   logic [fba_pkg::REQ_W-1:0]   remain_ff, remain_in;

   // result stage, waits on the registered ring read
   logic                        s1_valid_ff, s1_valid_in;
   fba_pkg::rsp_type            s1_rsp_ff, s1_rsp_in;
   logic                        s1_mem_ff, s1_mem_in;

   logic                        can_issue;
   logic [PW-1:0]               tail_init;
   logic [CW-1:0]               head_off;
   logic                        head_written;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
      ring_next = (pos == PW'(MAX_BLOCKS - 1)) ? '0 : pos + PW'(1);
   endfunction

   // room in the result queue for one more, counting the stage in flight
   assign can_issue = (QW'(rsp_count) + QW'(s1_valid_ff)) < QW'(fba_pkg::RSP_DEPTH);

   assign tail_init = (total >= CW'(MAX_BLOCKS)) ? '0 : PW'(total);

   // entries pushed since init sit in a window starting at init_tail;
   // the rest still hold their init value, which is the position itself
   always_comb begin
      if (head_ff >= init_tail_ff) begin
         head_off = CW'(head_ff - init_tail_ff);
      end else begin
         head_off = CW'(head_ff) + CW'(MAX_BLOCKS) - CW'(init_tail_ff);
      end
   end
   assign head_written = (head_off < push_cnt_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      init_tail_in = init_tail_ff;
      push_cnt_in  = push_cnt_ff;
      remain_in    = remain_ff;
      s1_valid_in  = 1'b0;
      s1_rsp_in    = '0;
      s1_mem_in    = 1'b0;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (cmd_valid && can_issue) begin
               cmd_pop              = 1'b1;
               s1_valid_in          = 1'b1;
               s1_rsp_in.status     = fba_pkg::STATUS_OK;
               s1_rsp_in.last       = 1'b1;
               s1_rsp_in.free_count = fba_pkg::COUNT_W'(free_ff);
               unique case (cmd_data.kind)
                  fba_pkg::CMD_INIT: begin
                     head_in              = '0;
                     tail_in              = tail_init;
                     init_tail_in         = tail_init;
                     push_cnt_in          = '0;
                     free_in              = total;
                     s1_rsp_in.free_count = fba_pkg::COUNT_W'(total);
                  end
                  fba_pkg::CMD_ALLOC: begin
                     if (XW'(cmd_data.count) > XW'(free_ff)) begin
                        s1_rsp_in.status = fba_pkg::STATUS_SHORT;
                     end else begin
                        // grants come from the alloc state
                        s1_valid_in = 1'b0;
                        remain_in   = cmd_data.count;
                        state_in    = fba_pkg::ST_ALLOC;
                     end
                  end
                  fba_pkg::CMD_FREE: begin
                     if (free_ff >= CW'(MAX_BLOCKS)) begin
                        s1_rsp_in.status = fba_pkg::STATUS_FULL;
                     end else begin
                        mem_we               = 1'b1;
                        tail_in              = ring_next(tail_ff);
                        free_in              = free_ff + CW'(1);
                        s1_rsp_in.free_count = fba_pkg::COUNT_W'(free_ff + CW'(1));
                        if (push_cnt_ff != CW'(MAX_BLOCKS)) begin
                           push_cnt_in = push_cnt_ff + CW'(1);
                        end
                     end
                  end
                  fba_pkg::CMD_RANGE: begin
                     s1_rsp_in.status = fba_pkg::STATUS_RANGE;
                  end
                  default: begin
                     // zero-size allocate: plain ok
                     s1_rsp_in.status = fba_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         fba_pkg::ST_ALLOC: begin
            if (can_issue) begin
               mem_re                  = 1'b1;
               s1_valid_in             = 1'b1;
               s1_mem_in               = head_written;
               s1_rsp_in.granted_block = fba_pkg::BLOCK_W'(head_ff);
               s1_rsp_in.index_valid   = 1'b1;
               s1_rsp_in.status        = fba_pkg::STATUS_OK;
               s1_rsp_in.free_count    = fba_pkg::COUNT_W'(free_ff - CW'(1));
               s1_rsp_in.last          = (remain_ff == fba_pkg::REQ_W'(1));
               head_in                 = ring_next(head_ff);
               free_in                 = free_ff - CW'(1);
               remain_in               = remain_ff - fba_pkg::REQ_W'(1);
               if (remain_ff == fba_pkg::REQ_W'(1)) begin
                  state_in = fba_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = fba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fba_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         init_tail_ff <= '0;
         push_cnt_ff  <= '0;
         remain_ff    <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         init_tail_ff <= init_tail_in;
         push_cnt_ff  <= push_cnt_in;
         remain_ff    <= remain_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_rsp_ff <= s1_rsp_in;
      s1_mem_ff <= s1_mem_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[tail_ff] <= cmd_data.index;
      end
      if (mem_re) begin
         mem_q_ff <= ring_mem[head_ff];
      end
   end

   always_comb begin
      rsp_push = s1_valid_ff;
      rsp_data = s1_rsp_ff;
      if (s1_mem_ff) begin
         rsp_data.granted_block = mem_q_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/free_block_fifo_allocator.sv
// free_block_fifo_allocator: top level, block total register and wiring
// depends on fba_pkg, fba_front, fba_back, fba_rsp_queue
`default_nettype none

//  channel   ports                          width / type        direction
//  request   req_push req_full req_data     fba_pkg::req_type   in
//  result    rsp_pop rsp_empty rsp_data     fba_pkg::rsp_type   out
//  csr       csr_write csr_data             11 bits             in
//
//  init, free, error and zero-size transactions: one result each
//  allocate of n blocks: n results (one short result if too few are free), one per
//    cycle while the result queue has room; the single ring read port sets that pace
//  init takes no fill sweep: untouched ring entries read back as their own position
//  synchronous active-high reset; the ring is empty and the total register is 1024
//  req_full rises when the two-entry command queue fills; results wait in a
//    four-entry queue, and once that fills the back end holds until rsp_pop drains it

module free_block_fifo_allocator #(
   parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_BURST  = fba_pkg::DEF_MAX_BURST
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire fba_pkg::req_type              req_data,
   input  wire logic                          rsp_pop,
   output logic                               rsp_empty,
   output fba_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_write,
   input  wire logic [fba_pkg::COUNT_W-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int EW = (CW > fba_pkg::COUNT_W) ? CW : fba_pkg::COUNT_W;
   localparam int NW = $clog2(fba_pkg::RSP_DEPTH + 1);

   // block total register
   logic [fba_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [CW-1:0]               total_eff;

   // front to back command channel
   logic             cmd_valid;
   fba_pkg::cmd_type cmd_data;
   logic             cmd_pop;

   // back to result queue
   logic             rsp_push;
   fba_pkg::rsp_type rsp_push_data;
   logic [NW-1:0]    rsp_count;

   assign total_in = csr_write ? csr_data : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= fba_pkg::CSR_TOTAL_RESET;
      end else begin
         total_ff <= total_in;
      end
   end

   // zero or anything above the ring size means the whole ring
   always_comb begin
      if (total_ff == '0 || EW'(total_ff) > EW'(MAX_BLOCKS)) begin
         total_eff = CW'(MAX_BLOCKS);
      end else begin
         total_eff = CW'(total_ff);
      end
   end

   fba_front #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MAX_BURST  (MAX_BURST)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .total     (total_eff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   fba_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .total     (total_eff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_push_data)
   );

   fba_rsp_queue #(
      .DEPTH (fba_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_data (rsp_data),
      .count     (rsp_count)
   );

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for free_block_fifo_allocator, an in-line pool predictor
// checks every result transaction; depends on fba_pkg and the rtl top level only

module tb;

   localparam int POOL_SLOTS      = fba_pkg::DEF_MAX_BLOCKS;
   localparam int BURST_CAP       = fba_pkg::DEF_MAX_BURST;
   localparam logic [1:0] OP_UNUSED = 2'd3;    // spare opcode, block must ignore it
   localparam int IDLE_PCT        = 27;        // chance per cycle that a side holds off
   localparam int SETTLE_CYCLES   = 16;        // covers the pipe plus queues
   localparam int STALL_LIMIT     = 4000;      // cycles with no transaction while busy
   localparam int ITEMS_PER_PHASE = 60;
   localparam int NUM_TOTALS      = 8;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_push  = 1'b0;
   logic                        req_full;
   fba_pkg::req_type            req_data  = '0;
   logic                        rsp_pop   = 1'b0;
   logic                        rsp_empty;
   fba_pkg::rsp_type            rsp_data;
   logic                        csr_write = 1'b0;
   logic [fba_pkg::COUNT_W-1:0] csr_data  = '0;

   free_block_fifo_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   // shadow of the pool: ring contents, pointers, free total and block total register
   logic [fba_pkg::BLOCK_W-1:0] ring_copy [POOL_SLOTS];
   int                          head_copy  = 0;
   int                          tail_copy  = 0;
   int                          free_copy  = 0;
   logic [fba_pkg::COUNT_W-1:0] total_copy = fba_pkg::CSR_TOTAL_RESET;

   fba_pkg::req_type queued_reqs [$];   // request transactions not yet taken by the block
   fba_pkg::rsp_type owed_rsps [$];     // results the block still owes, oldest first

   bit steady     = 1'b0;      // when set neither side idles
   int mismatches = 0;
   int n_init     = 0;
   int n_alloc    = 0;
   int n_free     = 0;
   int n_ignored  = 0;
   int n_results  = 0;
   int n_totals   = 0;
   int stalled    = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // zero and anything past the ring size both mean a full-size pool
   function automatic int eff_total(input logic [fba_pkg::COUNT_W-1:0] v);
      if (v == 0 || v > POOL_SLOTS) return POOL_SLOTS;
      return int'(v);
   endfunction

   // apply one accepted request to the shadow pool and queue the results it owes
   task automatic pool_apply(input fba_pkg::req_type r);
      int               tot;
      int               want;
      int               i;
      fba_pkg::rsp_type o;
      tot = eff_total(total_copy);
      o = '0;
      o.status = fba_pkg::STATUS_OK;
      o.last = 1'b1;
      case (r.operation)
         fba_pkg::OP_INIT: begin
            n_init++;
            for (i = 0; i < tot; i++) ring_copy[i] = fba_pkg::BLOCK_W'(i);
            head_copy = 0;
            tail_copy = (tot >= POOL_SLOTS) ? 0 : tot;
            free_copy = tot;
            o.free_count = fba_pkg::COUNT_W'(free_copy);
            owed_rsps.push_back(o);
         end
         fba_pkg::OP_ALLOC: begin
            n_alloc++;
            want = (r.block_count > BURST_CAP) ? BURST_CAP : int'(r.block_count);
            if (want == 0 || want > free_copy) begin
               // zero-size asks answer ok, short pools answer with one failure
               if (want != 0) o.status = fba_pkg::STATUS_SHORT;
               o.free_count = fba_pkg::COUNT_W'(free_copy);
               owed_rsps.push_back(o);
            end else begin
               for (i = 0; i < want; i++) begin
                  o.granted_block = ring_copy[head_copy];
                  o.index_valid = 1'b1;
                  head_copy = (head_copy + 1) % POOL_SLOTS;
                  free_copy--;
                  o.free_count = fba_pkg::COUNT_W'(free_copy);
                  o.last = (i == want - 1);
                  owed_rsps.push_back(o);
               end
            end
         end
         fba_pkg::OP_FREE: begin
            n_free++;
            // range check comes before the full check; duplicates go in unnoticed
            if (int'(r.block_index) >= tot) begin
               o.status = fba_pkg::STATUS_RANGE;
            end else if (free_copy >= POOL_SLOTS) begin
               o.status = fba_pkg::STATUS_FULL;
            end else begin
               ring_copy[tail_copy] = r.block_index;
               tail_copy = (tail_copy + 1) % POOL_SLOTS;
               free_copy++;
            end
            o.free_count = fba_pkg::COUNT_W'(free_copy);
            owed_rsps.push_back(o);
         end
         default: n_ignored++;
      endcase
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns, result %0d: %s", $realtime, n_results, what);
      mismatches++;
   endtask

   task automatic field_check(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic check_result(input fba_pkg::rsp_type got);
      fba_pkg::rsp_type want;
      if (owed_rsps.size() == 0) begin
         report_mismatch("result transaction with nothing outstanding");
      end else begin
         want = owed_rsps.pop_front();
         field_check("granted_block", 16'(got.granted_block), 16'(want.granted_block));
         field_check("index_valid", 16'(got.index_valid), 16'(want.index_valid));
         field_check("status", 16'(got.status), 16'(want.status));
         field_check("free_count", 16'(got.free_count), 16'(want.free_count));
         field_check("last", 16'(got.last), 16'(want.last));
      end
      n_results++;
   endtask

   task automatic queue_req(input logic [1:0] op, input int count, input int index);
      fba_pkg::req_type r;
      r.operation = op;
      r.block_count = fba_pkg::REQ_W'(count);
      r.block_index = fba_pkg::BLOCK_W'(index);
      queued_reqs.push_back(r);
   endtask

   // wait for every request to go in and every result to come out, then let the pipe empty
   task automatic drain();
      while (queued_reqs.size() != 0 || req_push || owed_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only ever issued while the block is idle
   task automatic write_total(input logic [fba_pkg::COUNT_W-1:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_data  <= v;
      total_copy = v;
      @(posedge clock);
      csr_write <= 1'b0;
      n_totals++;
   endtask

   // one random phase: opens with an init, then mostly small allocates and in-range
   // frees so the ring keeps cycling, with some oversized, zero, stray and spare codes
   task automatic random_batch(input int n);
      int               made;
      int               tot;
      int               roll;
      int               sub;
      fba_pkg::req_type r;
      tot = eff_total(total_copy);
      @(negedge clock);
      queue_req(fba_pkg::OP_INIT, $urandom_range(127), $urandom_range(1023));
      made = 1;
      while (made < n) begin
         roll = $urandom_range(99);
         sub = $urandom_range(99);
         r.block_count = fba_pkg::REQ_W'($urandom_range(127));
         r.block_index = fba_pkg::BLOCK_W'($urandom_range(1023));
         if (roll < 5) begin
            r.operation = fba_pkg::OP_INIT;
         end else if (roll < 42) begin
            r.operation = fba_pkg::OP_ALLOC;
            if (sub < 80)
               r.block_count = fba_pkg::REQ_W'($urandom_range(1, 4));
            else if (sub < 90)
               r.block_count = fba_pkg::REQ_W'($urandom_range(5, BURST_CAP));
            else if (sub < 96)
               r.block_count = fba_pkg::REQ_W'($urandom_range(BURST_CAP + 1, 127));
            else
               r.block_count = '0;
         end else if (roll < 88) begin
            r.operation = fba_pkg::OP_FREE;
            r.block_index = fba_pkg::BLOCK_W'($urandom_range(tot - 1));
         end else if (roll < 95) begin
            r.operation = fba_pkg::OP_FREE;     // any index, out of range when the pool is small
         end else begin
            r.operation = OP_UNUSED;
         end
         queued_reqs.push_back(r);
         if (r.operation != OP_UNUSED) made++;
      end
   endtask

   // request driver: retire the head on acceptance, then offer the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) pool_apply(queued_reqs.pop_front());
         if (queued_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_push <= 1'b1;
            req_data <= queued_reqs[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor: check the transaction taken at this edge, then choose to pop or stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
         rsp_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // watchdog: only counts while something is still in flight
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stalled <= 0;
         else if (queued_reqs.size() != 0 || owed_rsps.size() != 0)
            stalled <= stalled + 1;
         if (stalled >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic [fba_pkg::COUNT_W-1:0] totals [NUM_TOTALS];
      int k;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, default total of 1024: empty ring first, then full ring
      @(negedge clock);
      queue_req(fba_pkg::OP_ALLOC, 1, 0);          // nothing free yet
      queue_req(fba_pkg::OP_FREE, 0, 5);           // push into the empty ring
      queue_req(fba_pkg::OP_ALLOC, 1, 1023);       // hands back block 5
      queue_req(fba_pkg::OP_ALLOC, 0, 0);          // zero-size ask
      queue_req(fba_pkg::OP_INIT, 127, 1023);
      queue_req(fba_pkg::OP_FREE, 127, 3);         // ring already full
      queue_req(fba_pkg::OP_ALLOC, BURST_CAP, 0);
      queue_req(fba_pkg::OP_ALLOC, 127, 0);        // oversized, clipped to the burst cap
      queue_req(OP_UNUSED, 127, 1023);             // spare code, no result
      queue_req(fba_pkg::OP_FREE, 0, 1023);
      queue_req(fba_pkg::OP_FREE, 0, 0);
      queue_req(fba_pkg::OP_ALLOC, 1, 0);
      drain();

      // directed, one-block pool: range error and a duplicate free
      write_total(fba_pkg::COUNT_W'(1));
      @(negedge clock);
      queue_req(fba_pkg::OP_INIT, 0, 0);
      queue_req(fba_pkg::OP_FREE, 0, 1);           // at the total, out of range
      queue_req(fba_pkg::OP_FREE, 0, 0);           // block 0 is already free, goes in twice
      queue_req(fba_pkg::OP_ALLOC, 2, 0);
      queue_req(fba_pkg::OP_ALLOC, 1, 0);          // short now
      queue_req(fba_pkg::OP_FREE, 0, 1023);
      drain();

      // random phases over several totals, saturating and wrapping values included
      totals[0] = fba_pkg::COUNT_W'(1024);
      totals[1] = fba_pkg::COUNT_W'(2047);
      totals[2] = fba_pkg::COUNT_W'(0);
      totals[3] = fba_pkg::COUNT_W'(1);
      totals[4] = fba_pkg::COUNT_W'(3);
      totals[5] = fba_pkg::COUNT_W'($urandom_range(2, 1023));
      totals[6] = fba_pkg::COUNT_W'($urandom_range(2, 1023));
      totals[7] = fba_pkg::COUNT_W'(1024);
      for (k = 0; k < NUM_TOTALS; k++) begin
         write_total(totals[k]);
         steady = (k == 2);                // one whole phase with no idling
         random_batch(ITEMS_PER_PHASE);
         drain();
      end
      steady = 1'b0;

      $display("covered %0d init, %0d allocate, %0d free and %0d spare-code requests",
               n_init, n_alloc, n_free, n_ignored);
      $display("checked %0d result transactions under %0d block total settings",
               n_results, n_totals);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
